// ===== src/pba_pkg.sv =====
// Shared types and constants for the page bitmap allocator.
// Holds map geometry, request and status codes, and the map access struct.
// No dependencies.
`timescale 1ns / 1ps

package pba_pkg;

    // Map geometry
    localparam int MAX_PAGES     = 4096;
    localparam int MAP_WORD_BITS = 64;
    localparam int MAP_WORDS     = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WORD_AW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W         = $clog2(MAP_WORD_BITS);

    // Field widths
    localparam int PAGE_W     = 12;
    localparam int CNT_W      = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    // Usable page limit: smallest of MAX_PAGES and the span of a page index
    localparam int INDEX_SPAN = 4096;
    localparam int LIMIT_CAP  = (MAX_PAGES < INDEX_SPAN) ? MAX_PAGES : INDEX_SPAN;

    typedef logic [MAP_WORD_BITS-1:0] word_t;
    typedef logic [WORD_AW-1:0]       waddr_t;

    typedef enum logic [1:0] {
        FUNC_TEST = 2'd0,
        FUNC_SET  = 2'd1,
        FUNC_CLR  = 2'd2,
        FUNC_FIND = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_READY = 2'd1,
        STAT_RANGE     = 2'd2,
        STAT_NO_FREE   = 2'd3
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REGION_READY = 1'b0,
        CFG_PAGE_COUNT   = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DONE
    } state_t;

    // Map memory access: one read and one write port
    typedef struct packed {
        logic   rd_en;
        waddr_t rd_addr;
        logic   wr_en;
        waddr_t wr_addr;
        word_t  wr_data;
    } map_req_t;

endpackage

// ===== src/page_bitmap_allocator_core.sv =====
// Page bitmap allocator top level: request sequencer, config registers, output stage.
// Depends on pba_pkg, pba_map_mem and pba_lowest_set.
`timescale 1ns / 1ps

// One bit per page (1 = used) is kept in a 64-word by 64-bit map memory,
// all free after reset. Each request tests a page, marks it used, marks it
// free, or searches upward from the start page for the first free page below
// the page limit (the configured page total, capped at 4096). region_ready is
// checked first, then the index against the limit; a failed check answers
// with a status and leaves the map alone. Test, mark and free make one map
// read, then write the bit update back while the result is registered. A
// search walks the map words from the start word until a free page turns up
// or the last word below the limit is done (at most 64 words), reading them
// through the map's single registered read port. A rejected request is
// answered at once: its result is offered right after the accepting edge.
// One request is in flight at a time; s_tready comes back in the cycle the
// result is offered, so a new request is taken only once the last one's
// result is offered. A finished result sits in the output register and
// s_tready stays up while it waits; a second result that finishes before
// the first is taken is parked and holds s_tready low.
// Configuration writes are always taken (cfg_ready is tied high) and must
// only be issued while no request is outstanding.

module page_bitmap_allocator_core
    import pba_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // request channel
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [1:0] func, [13:2] page number, [15:14] zero

    // result channel
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // [1:0] status, [2] page_used,
                                             // [14:3] found_index, [15] zero

    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CNT_W-1:0]      cfg_data
);

    localparam logic [CNT_W-1:0] LIMIT_CAP_V = CNT_W'(LIMIT_CAP);

    // ---------------- configuration registers ----------------
    logic             region_ready_reg;
    logic [CNT_W-1:0] pg_total_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_ready_reg <= 1'b0;
            pg_total_reg     <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_index))
                CFG_REGION_READY: region_ready_reg <= cfg_data[0];
                CFG_PAGE_COUNT:   pg_total_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- request fields ----------------
    func_t             in_func;
    logic [PAGE_W-1:0] in_idx;
    logic [CNT_W-1:0]  cur_lim;

    assign in_func = func_t'(s_tdata[1:0]);
    assign in_idx  = s_tdata[PAGE_W+1:2];
    assign cur_lim = (pg_total_reg > LIMIT_CAP_V) ? LIMIT_CAP_V : pg_total_reg;

    // ---------------- sequencer state ----------------
    state_t            state_reg,  state_next;
    func_t             func_reg,   func_next;
    logic [PAGE_W-1:0] idx_reg,    idx_next;
    waddr_t            word_reg,   word_next;
    logic              first_reg,  first_next;
    logic [CNT_W-1:0]  lim_reg,    lim_next;

    // parked result while the output stage is full
    status_t           res_status_reg, res_status_next;
    logic              res_used_reg,   res_used_next;
    logic [PAGE_W-1:0] res_found_reg,  res_found_next;

    // output stage
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg,  m_tdata_next;

    // ---------------- map memory and search ----------------
    map_req_t         mem_req;
    word_t            rd_word;
    word_t            free_vec;
    word_t            lo_mask;
    word_t            hi_mask;
    logic             free_hit;
    logic [BIT_W-1:0] free_pos;
    logic [BIT_W-1:0] idx_bit;
    logic [BIT_W-1:0] lim_bit;
    logic [CNT_W-1:0] lim_word;
    logic [CNT_W-1:0] last_word;
    logic             more_words;

    pba_map_mem u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mem_req),
        .rd_data (rd_word)
    );

    assign idx_bit    = idx_reg[BIT_W-1:0];
    assign lim_bit    = lim_reg[BIT_W-1:0];
    assign lim_word   = lim_reg >> BIT_W;
    assign last_word  = (lim_reg - CNT_W'(1)) >> BIT_W;
    assign more_words = CNT_W'(word_reg) < last_word;

    // candidate pages: free, at or above the start, below the limit
    assign lo_mask  = first_reg ? ({MAP_WORD_BITS{1'b1}} << idx_bit) : {MAP_WORD_BITS{1'b1}};
    assign hi_mask  = (CNT_W'(word_reg) == lim_word) ? ~({MAP_WORD_BITS{1'b1}} << lim_bit)
                                                     : {MAP_WORD_BITS{1'b1}};
    assign free_vec = ~rd_word & lo_mask & hi_mask;

    pba_lowest_set u_find (
        .vec (free_vec),
        .hit (free_hit),
        .pos (free_pos)
    );

    // ---------------- next state ----------------
    logic              out_free;
    logic              fin;
    status_t           fin_status;
    logic              fin_used;
    logic [PAGE_W-1:0] fin_found;

    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        func_next       = func_reg;
        idx_next        = idx_reg;
        word_next       = word_reg;
        first_next      = first_reg;
        lim_next        = lim_reg;
        res_status_next = res_status_reg;
        res_used_next   = res_used_reg;
        res_found_next  = res_found_reg;
        mem_req         = '0;
        fin             = 1'b0;
        fin_status      = STAT_OK;
        fin_used        = 1'b0;
        fin_found       = '0;

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    func_next  = in_func;
                    idx_next   = in_idx;
                    word_next  = WORD_AW'(in_idx >> BIT_W);
                    first_next = 1'b1;
                    lim_next   = cur_lim;
                    if (!region_ready_reg) begin
                        fin        = 1'b1;
                        fin_status = STAT_NOT_READY;
                    end else if ({1'b0, in_idx} >= cur_lim) begin
                        fin        = 1'b1;
                        fin_status = STAT_RANGE;
                    end else begin
                        mem_req.rd_en   = 1'b1;
                        mem_req.rd_addr = WORD_AW'(in_idx >> BIT_W);
                        state_next      = ST_READ;
                    end
                end
            end

            ST_READ: begin
                case (func_reg)
                    FUNC_TEST: begin
                        fin      = 1'b1;
                        fin_used = rd_word[idx_bit];
                    end
                    FUNC_SET, FUNC_CLR: begin
                        mem_req.wr_en            = 1'b1;
                        mem_req.wr_addr          = word_reg;
                        mem_req.wr_data          = rd_word;
                        mem_req.wr_data[idx_bit] = (func_reg == FUNC_SET);
                        fin                      = 1'b1;
                    end
                    FUNC_FIND: begin
                        if (free_hit) begin
                            fin       = 1'b1;
                            fin_found = PAGE_W'({word_reg, free_pos});
                        end else if (more_words) begin
                            mem_req.rd_en   = 1'b1;
                            mem_req.rd_addr = word_reg + waddr_t'(1);
                            word_next       = word_reg + waddr_t'(1);
                            first_next      = 1'b0;
                        end else begin
                            fin        = 1'b1;
                            fin_status = STAT_NO_FREE;
                        end
                    end
                    default: ;
                endcase
            end

            ST_DONE: begin
                fin        = 1'b1;
                fin_status = res_status_reg;
                fin_used   = res_used_reg;
                fin_found  = res_found_reg;
            end

            default: state_next = ST_IDLE;
        endcase

        if (fin) begin
            if (out_free) begin
                state_next = ST_IDLE;
            end else begin
                state_next      = ST_DONE;
                res_status_next = fin_status;
                res_used_next   = fin_used;
                res_found_next  = fin_found;
            end
        end
    end

    // ---------------- output stage ----------------
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (fin && out_free) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = OUT_DATA_W'({fin_found, fin_used, fin_status});
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg       <= func_next;
        idx_reg        <= idx_next;
        word_reg       <= word_next;
        first_reg      <= first_next;
        lim_reg        <= lim_next;
        res_status_reg <= res_status_next;
        res_used_reg   <= res_used_next;
        res_found_reg  <= res_found_next;
        m_tdata_reg    <= m_tdata_next;
    end

endmodule

// ===== src/pba_map_mem.sv =====
// Page usage map storage: one word per row, registered read.
// Per-row valid bits make unwritten rows read as all free after reset.
// Depends on pba_pkg.
`timescale 1ns / 1ps

module pba_map_mem
    import pba_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  map_req_t req,
    output word_t    rd_data
);

    word_t                mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] valid_reg;
    logic [MAP_WORDS-1:0] valid_next;
    word_t                mem_q_reg;
    logic                 hit_q_reg;

    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            mem_q_reg <= mem[req.rd_addr];
        end
    end

    always_comb begin
        valid_next = valid_reg;
        if (req.wr_en) begin
            valid_next[req.wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            hit_q_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            if (req.rd_en) begin
                hit_q_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    // never-written row reads as free
    assign rd_data = hit_q_reg ? mem_q_reg : '0;

endmodule

// ===== src/pba_lowest_set.sv =====
// Finds the lowest set bit of a map word.
// Isolates it with a two's complement and encodes the one-hot result.
// Depends on pba_pkg.
`timescale 1ns / 1ps

module pba_lowest_set
    import pba_pkg::*;
(
    input  word_t            vec,
    output logic             hit,
    output logic [BIT_W-1:0] pos
);

    word_t onehot;

    assign onehot = vec & (~vec + word_t'(1));
    assign hit    = |vec;

    always_comb begin
        for (int k = 0; k < BIT_W; k++) begin
            pos[k] = 1'b0;
            for (int b = 0; b < MAP_WORD_BITS; b++) begin
                if (((b >> k) & 1) == 1) begin
                    pos[k] = pos[k] | onehot[b];
                end
            end
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for page_bitmap_allocator_core: request, result and config streams.
// Keeps its own copy of the page map and checks each result transaction field by field.
// Depends on pba_pkg and the core RTL.
`timescale 1ns / 1ps

module tb_top;
    import pba_pkg::*;

    // Run limits. The slowest legal item is the largest idle gap, a full
    // 64-word search and the largest result stall; roughly 700 items fit well
    // inside CYCLE_LIMIT.
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYC  = 4;     // quiet cycles before a register write
    localparam int TAIL_CYC    = 80;    // longer than a full 64-word search

    // Ports
    logic                  aclk;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata   = '0;   // [1:0] func, [13:2] page number, [15:14] zero
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;          // [1:0] status, [2] page_used,
                                             // [14:3] found_index, [15] zero
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CNT_W-1:0]      cfg_data  = '0;

    page_bitmap_allocator_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Stimulus plan. A request, a register write, a drain (wait until no answer
    // is outstanding), or a pacing change that sets the idle draw on both sides.
    typedef enum logic [1:0] {
        OP_REQ,
        OP_WRITE,
        OP_DRAIN,
        OP_PACE
    } op_kind_t;

    typedef struct packed {
        op_kind_t          kind;
        func_t             fn;
        logic [PAGE_W-1:0] idx;
        cfg_reg_t          reg_sel;
        logic [CNT_W-1:0]  wval;
        int                gap_max;
        int                stall_max;
    } plan_op_t;

    // Expected result transaction
    typedef struct {
        status_t           status;
        logic              used;
        logic [PAGE_W-1:0] found;
    } page_answer_t;

    plan_op_t     plan[$];
    page_answer_t answers_due[$];

    // Predictor state: our own copy of the page map and both registers
    logic [LIMIT_CAP-1:0] page_bits;
    logic                 ready_q;
    logic [CNT_W-1:0]     count_q;

    // Handshake flags, set at the rising edge and read by the falling-edge drivers
    logic req_fired = 1'b0;
    logic cfg_fired = 1'b0;
    logic rsp_fired = 1'b0;

    int cycle_cnt    = 0;
    int mismatches   = 0;
    int reqs_planned = 0;
    int writes_done  = 0;
    int longest_walk = 0;
    int func_seen[4];
    int status_seen[4];

    int idle_cnt     = 0;   // driver: cycles with nothing outstanding
    int gap_left     = 0;   // driver: idle cycles before the next request
    int tx_gap_max   = 0;
    int rx_stall_max = 0;
    int stall_left   = 0;   // receiver: cycles m_tready stays low

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // One line per mismatch, counted
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch at cycle %0d: %s got %0d want %0d", cycle_cnt, what, got, want);
        mismatches++;
    endtask

    // Apply one request to the predicted map and work out the answer.
    // Ready is checked first, then the index against the capped page count.
    function automatic page_answer_t serve_request(input func_t fn,
                                                   input logic [PAGE_W-1:0] pg);
        page_answer_t r;
        int lim;
        int i;
        int stop;
        r.status = STAT_OK;
        r.used   = 1'b0;
        r.found  = '0;
        lim = (count_q > LIMIT_CAP) ? LIMIT_CAP : int'(count_q);
        if (!ready_q) begin
            r.status = STAT_NOT_READY;
        end else if (int'(pg) >= lim) begin
            r.status = STAT_RANGE;
        end else begin
            case (fn)
                FUNC_TEST: r.used = page_bits[pg];
                FUNC_SET:  page_bits[pg] = 1'b1;
                FUNC_CLR:  page_bits[pg] = 1'b0;
                default: begin
                    // upward walk, stops at the first free page below the limit
                    r.status = STAT_NO_FREE;
                    for (i = int'(pg); i < lim && r.status == STAT_NO_FREE; i++) begin
                        if (!page_bits[i]) begin
                            r.status = STAT_OK;
                            r.found  = i[PAGE_W-1:0];
                        end
                    end
                    stop = (r.status == STAT_OK) ? int'(r.found) : lim - 1;
                    stop = stop / MAP_WORD_BITS - int'(pg) / MAP_WORD_BITS + 1;
                    if (stop > longest_walk)
                        longest_walk = stop;
                end
            endcase
        end
        return r;
    endfunction

    // Monitor and scoreboard: everything sampled at the rising edge
    always @(posedge aclk) begin : watch_ports
        page_answer_t want;
        if (!aresetn) begin
            req_fired <= 1'b0;
            cfg_fired <= 1'b0;
            rsp_fired <= 1'b0;
            page_bits = '0;
            ready_q   = 1'b0;
            count_q   = '0;
            answers_due.delete();
        end else begin
            req_fired <= s_tvalid && s_tready;
            cfg_fired <= cfg_valid && cfg_ready;
            rsp_fired <= m_tvalid && m_tready;

            // check the result first: it always belongs to an earlier request
            if (m_tvalid && m_tready) begin
                if (answers_due.size() == 0) begin
                    report_mismatch("result with no request, tdata", m_tdata, 0);
                end else begin
                    want = answers_due.pop_front();
                    status_seen[want.status]++;
                    if (m_tdata[1:0] !== want.status)
                        report_mismatch("status", m_tdata[1:0], want.status);
                    if (m_tdata[2] !== want.used)
                        report_mismatch("page_used", m_tdata[2], want.used);
                    if (m_tdata[14:3] !== want.found)
                        report_mismatch("found_index", m_tdata[14:3], want.found);
                    if (m_tdata[15] !== 1'b0)
                        report_mismatch("pad bit", m_tdata[15], 0);
                end
            end

            if (cfg_valid && cfg_ready) begin
                writes_done++;
                if (cfg_index == CFG_REGION_READY)
                    ready_q = cfg_data[0];
                else
                    count_q = cfg_data;
            end

            if (s_tvalid && s_tready) begin
                func_seen[s_tdata[1:0]]++;
                answers_due.push_back(serve_request(func_t'(s_tdata[1:0]), s_tdata[13:2]));
            end
        end
    end

    // Request and config driver, fed from the plan. Inputs move on the falling edge;
    // valid is assigned once per edge so back-to-back transactions keep it high.
    always @(negedge aclk) begin : drive_plan
        plan_op_t op;
        logic nx_valid;
        logic nx_cfg;
        nx_valid = s_tvalid;
        nx_cfg   = cfg_valid;
        if (!aresetn) begin
            nx_valid = 1'b0;
            nx_cfg   = 1'b0;
            idle_cnt = 0;
            gap_left = 0;
        end else begin
            if (s_tvalid && req_fired) begin
                nx_valid = 1'b0;
                gap_left = $urandom_range(0, tx_gap_max);
            end
            if (cfg_valid && cfg_fired)
                nx_cfg = 1'b0;
            idle_cnt = (answers_due.size() == 0 && !nx_valid) ? idle_cnt + 1 : 0;

            if (!nx_valid && !nx_cfg && plan.size() > 0) begin
                op = plan[0];
                case (op.kind)
                    OP_REQ: begin
                        if (gap_left > 0) begin
                            gap_left--;
                        end else begin
                            nx_valid = 1'b1;
                            s_tdata  <= {2'b00, op.idx, op.fn};
                            void'(plan.pop_front());
                        end
                    end
                    OP_WRITE: begin
                        // registers only change with the block quiet
                        if (idle_cnt >= SETTLE_CYC) begin
                            nx_cfg = 1'b1;
                            cfg_index <= op.reg_sel;
                            cfg_data  <= op.wval;
                            void'(plan.pop_front());
                        end
                    end
                    OP_DRAIN: begin
                        if (idle_cnt >= SETTLE_CYC)
                            void'(plan.pop_front());
                    end
                    default: begin
                        tx_gap_max = op.gap_max;
                        rx_stall_max <= op.stall_max;
                        void'(plan.pop_front());
                    end
                endcase
            end
        end
        s_tvalid  <= nx_valid;
        cfg_valid <= nx_cfg;
    end

    // Result receiver: after each result transaction, hold off a random count
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            stall_left = 0;
        end else if (rsp_fired || !m_tready) begin
            if (rsp_fired)
                stall_left = $urandom_range(0, rx_stall_max);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d answers outstanding",
                     cycle_cnt, answers_due.size());
            $display("status: fail");
            $finish;
        end
    end

    // Plan builders
    task automatic push_req(input func_t fn, input int pg);
        plan_op_t op;
        op      = '0;
        op.kind = OP_REQ;
        op.fn   = fn;
        op.idx  = pg[PAGE_W-1:0];
        plan.push_back(op);
        reqs_planned++;
    endtask

    task automatic push_write(input cfg_reg_t sel, input int val);
        plan_op_t op;
        op         = '0;
        op.kind    = OP_WRITE;
        op.reg_sel = sel;
        op.wval    = val[CNT_W-1:0];
        plan.push_back(op);
    endtask

    task automatic push_drain();
        plan_op_t op;
        op      = '0;
        op.kind = OP_DRAIN;
        plan.push_back(op);
    endtask

    task automatic push_pace(input int gap_max, input int stall_max);
        plan_op_t op;
        op           = '0;
        op.kind      = OP_PACE;
        op.gap_max   = gap_max;
        op.stall_max = stall_max;
        plan.push_back(op);
    endtask

    // One random phase under fixed registers. Most traffic is runs of marks or
    // frees in a dense low window followed by searches from at or below the run start, so
    // searches cross word boundaries and hit full stretches. The rest is single
    // requests, indexes around the limit, and plain noise.
    task automatic random_phase(input int ready, input int cnt, input int quota,
                                input int gap_max, input int stall_max);
        int lim;
        int span;
        int stop_at;
        int r;
        int base;
        int len;
        int k;
        bit drained;
        lim  = (cnt > LIMIT_CAP) ? LIMIT_CAP : cnt;
        span = (lim > 384) ? 384 : lim;
        stop_at = reqs_planned + quota;
        drained = 1'b0;
        push_write(CFG_REGION_READY, ready);
        push_write(CFG_PAGE_COUNT, cnt);
        push_pace(gap_max, stall_max);
        while (reqs_planned < stop_at) begin
            // sender stops once mid-phase until every answer is back
            if (!drained && reqs_planned >= stop_at - quota / 2) begin
                push_drain();
                drained = 1'b1;
            end
            r    = $urandom_range(0, 99);
            base = (span > 0) ? $urandom_range(0, span - 1) : $urandom_range(0, 4095);
            if (r < 20) begin
                len = $urandom_range(1, 40);
                for (k = 0; k < len && base + k < LIMIT_CAP; k++)
                    push_req(FUNC_SET, base + k);
                push_req(FUNC_FIND, base);
            end else if (r < 30) begin
                len = $urandom_range(1, 16);
                for (k = 0; k < len && base + k < LIMIT_CAP; k++)
                    push_req(FUNC_CLR, base + k);
                push_req(FUNC_FIND, $urandom_range(0, base));
            end else if (r < 40) begin
                push_req(FUNC_CLR, base);
            end else if (r < 62) begin
                push_req(FUNC_FIND, base);
            end else if (r < 78) begin
                push_req(FUNC_TEST, base);
            end else if (r < 90) begin
                push_req(func_t'($urandom_range(0, 3)), lim - 1 + $urandom_range(0, 2));
            end else begin
                push_req(func_t'($urandom_range(0, 3)), $urandom_range(0, 4095));
            end
        end
    endtask

    initial begin
        // Directed part. Registers start at ready = 0 and count = 0.
        push_pace(4, 4);
        push_req(FUNC_TEST, 0);             // not ready
        push_req(FUNC_FIND, 4095);          // not ready wins over range
        push_write(CFG_REGION_READY, 1);
        push_req(FUNC_SET, 0);              // count 0: everything out of range
        push_write(CFG_PAGE_COUNT, 8191);   // capped to 4096
        push_req(FUNC_SET, 4095);
        push_req(FUNC_TEST, 4095);
        push_req(FUNC_TEST, 0);
        push_req(FUNC_FIND, 4095);          // last page used: no free page
        push_req(FUNC_CLR, 4095);
        push_req(FUNC_FIND, 4095);          // found index all ones
        push_req(FUNC_SET, 0);
        push_req(FUNC_FIND, 0);             // skips page 0
        push_req(FUNC_TEST, 0);
        push_write(CFG_PAGE_COUNT, 64);     // one word
        push_req(FUNC_TEST, 64);            // index equal to limit
        push_req(FUNC_FIND, 64);            // search start equal to limit
        push_req(FUNC_SET, 63);
        push_req(FUNC_FIND, 63);            // nothing free before the limit
        push_req(FUNC_CLR, 64);             // rejected, map untouched
        push_req(FUNC_FIND, 62);
        push_req(FUNC_CLR, 63);
        push_write(CFG_REGION_READY, 0);
        push_req(FUNC_SET, 5);              // in range, still not ready

        // Random part, several register settings and pacing mixes
        random_phase(1, 4096, 90, 16, 16);
        random_phase(1, 320,  90, 0,  0);
        random_phase(1, 1,    25, 16, 0);
        random_phase(1, 8191, 90, 0,  16);
        random_phase(0, 4096, 25, 3,  3);
        random_phase(1, 0,    15, 16, 16);
        random_phase(1, 65,   60, 0,  0);
        random_phase(1, $urandom_range(100, 4096), 90, 16, 16);
        random_phase(1, 4095, 100, 2, 16);

        // Reset once, then let the plan run out
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (plan.size() != 0 || s_tvalid || cfg_valid || answers_due.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYC) @(posedge aclk);

        $display("covered %0d requests (test %0d, mark %0d, free %0d, find %0d), %0d reg writes",
                 func_seen[0] + func_seen[1] + func_seen[2] + func_seen[3],
                 func_seen[FUNC_TEST], func_seen[FUNC_SET], func_seen[FUNC_CLR],
                 func_seen[FUNC_FIND], writes_done);
        $display("answers: ok %0d, not ready %0d, out of range %0d, no free %0d;",
                 status_seen[STAT_OK], status_seen[STAT_NOT_READY],
                 status_seen[STAT_RANGE], status_seen[STAT_NO_FREE]);
        $display("longest walk %0d words", longest_walk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("status: fail");
        end
        $finish;
    end

endmodule
